// ----- src/bis_pkg.sv -----
// shared types and constants for the bounded integer set
package bis_pkg;

  localparam int OP_W             = 2;
  localparam int VALUE_W          = 32;
  localparam int COUNT_W          = 7;
  localparam int DEFAULT_CAPACITY = 64;

  typedef logic [OP_W-1:0]           op_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_out_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_TEST   = 2'd2;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

// ----- src/bis_if.sv -----
// request and response channel interfaces
interface bis_req_if;
  import bis_pkg::*;
  logic   valid;
  logic   ready;
  op_t    operation;
  value_t value;
  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface bis_rsp_if;
  import bis_pkg::*;
  logic       valid;
  logic       ready;
  logic       ok;
  count_out_t element_count;
  modport source (output valid, output ok, output element_count, input ready);
  modport sink   (input valid, input ok, input element_count, output ready);
endinterface

// ----- src/bis_cell.sv -----
// one storage cell of the set: holds an entry, compares, appends on insert, shifts down on remove
module bis_cell #(
  parameter int CAPACITY = bis_pkg::DEFAULT_CAPACITY,
  parameter int INDEX    = 0,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  bis_pkg::cell_ctrl_t ctrl,
  input  bis_pkg::value_t     value,
  input  logic [CW-1:0]       count,
  input  logic                hit_in,
  input  bis_pkg::value_t     next_entry,
  output logic                hit_out,
  output bis_pkg::value_t     entry
);
  import bis_pkg::*;

  logic match;
  logic occupied;
  logic is_tail;

  assign occupied = CW'(INDEX) < count;
  assign is_tail  = CW'(INDEX) == count;
  assign hit_out  = hit_in | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.cmp_en) begin
      match <= occupied && (entry == value);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins_en && is_tail) begin
      entry <= value;
    end else if (ctrl.rem_en && hit_out) begin
      entry <= next_entry;
    end
  end

endmodule

// ----- src/bounded_integer_set.sv -----
// top level of the bounded integer set
// Holds up to CAPACITY distinct signed 32-bit values in a row of cells, packed
// in arrival order, plus a count (empty after reset). Each request inserts,
// removes or tests one value and returns one response with an ok flag and the
// count after the request. From acceptance to response a request is first
// registered, then every cell compares its entry with the value, then the hit
// ripples along the cell row, later entries shift down on a remove or the value
// is appended on an insert, and the response register is loaded. One request
// is in flight at a time; a new one is taken while a finished response waits
// to be taken, and the apply step waits for the response slot.
module bounded_integer_set #(
  parameter int CAPACITY = bis_pkg::DEFAULT_CAPACITY
) (
  input  logic         clk,
  input  logic         rst,
  bis_req_if.sink      req,
  bis_rsp_if.source    rsp
);
  import bis_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  op_t           op_q;
  value_t        value_q;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          ok_next;
  logic          apply_go;
  logic          present;
  logic          not_full;
  cell_ctrl_t    ctrl;

  logic [CAPACITY:0] hit;
  value_t            entry_w [CAPACITY];

  logic [CW+COUNT_W-1:0] count_wide;

  assign req.ready = (state == S_IDLE);
  assign apply_go  = (state == S_APPLY) && (!rsp.valid || rsp.ready);
  assign present   = hit[CAPACITY];
  assign not_full  = count < CW'(CAPACITY);

  always_comb begin
    ctrl.cmp_en = (state == S_CMP);
    ctrl.ins_en = apply_go && (op_q == OP_INSERT) && !present && not_full;
    ctrl.rem_en = apply_go && (op_q == OP_REMOVE);
  end

  always_comb begin
    count_next = count;
    ok_next    = 1'b0;
    case (op_q)
      OP_INSERT: begin
        if (!present && not_full) begin
          count_next = count + CW'(1);
          ok_next    = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (present) begin
          count_next = count - CW'(1);
          ok_next    = 1'b1;
        end
      end
      OP_TEST: begin
        ok_next = present;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  assign count_wide = {{COUNT_W{1'b0}}, count_next};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (apply_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_go) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q    <= req.operation;
      value_q <= req.value;
    end
    if (apply_go) begin
      rsp.ok            <= ok_next;
      rsp.element_count <= count_wide[COUNT_W-1:0];
    end
  end

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t next_entry;
    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = value_q;
    end else begin : g_mid
      assign next_entry = entry_w[i+1];
    end

    bis_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i),
      .CW       (CW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .value      (value_q),
      .count      (count),
      .hit_in     (hit[i]),
      .next_entry (next_entry),
      .hit_out    (hit[i+1]),
      .entry      (entry_w[i])
    );
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the bounded integer set: directed and random requests
module testbench;
  import bis_pkg::*;

  localparam int  CAPACITY      = DEFAULT_CAPACITY;
  localparam int  POOL_SIZE     = 80;
  localparam int  PHASE_ITEMS   = 580;
  localparam int  LONG_STALL    = 300;
  localparam int  DRAIN_CYCLES  = 8;
  localparam int  CYCLE_LIMIT   = 400000;
  localparam op_t OP_UNUSED     = 2'd3;

  typedef struct packed {
    logic       ok;
    count_out_t element_count;
  } set_result_t;

  typedef enum int {RX_FLOW, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  bis_req_if req ();
  bis_rsp_if rsp ();

  bounded_integer_set #(.CAPACITY(CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic [VALUE_W-1:0] held_values [CAPACITY];
  int                 held_count = 0;
  value_t             value_pool [POOL_SIZE];
  set_result_t        expected_results [$];

  int error_count      = 0;
  int request_count    = 0;
  int result_count     = 0;
  int accepted_inserts = 0;
  int accepted_removes = 0;
  int full_refusals    = 0;
  int cycle_count      = 0;
  bit long_stall_req   = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic set_result_t apply_request(op_t op, value_t v);
    int          slot;
    set_result_t res;
    slot = held_count;
    for (int i = held_count - 1; i >= 0; i--) begin
      if (held_values[i] == v) slot = i;
    end
    res.ok = 1'b0;
    case (op)
      OP_INSERT: begin
        if (slot == held_count && held_count < CAPACITY) begin
          held_values[held_count] = v;
          held_count++;
          res.ok = 1'b1;
          accepted_inserts++;
        end else if (slot == held_count) begin
          full_refusals++;
        end
      end
      OP_REMOVE: begin
        if (slot < held_count) begin
          for (int i = slot; i < held_count - 1; i++) held_values[i] = held_values[i + 1];
          held_count--;
          res.ok = 1'b1;
          accepted_removes++;
        end
      end
      OP_TEST: res.ok = (slot < held_count);
      default: res.ok = 1'b0;
    endcase
    res.element_count = count_out_t'(held_count);
    return res;
  endfunction

  task automatic send_request(op_t op, value_t v);
    req.valid     <= 1'b1;
    req.operation <= op;
    req.value     <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_results.push_back(apply_request(op, v));
    request_count++;
  endtask

  task automatic idle_cycles(int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_all_results();
    req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic refresh_pool();
    foreach (value_pool[i]) value_pool[i] = value_t'($urandom);
    value_pool[0] = 32'sh0000_0000;
    value_pool[1] = 32'shFFFF_FFFF;
    value_pool[2] = 32'sh8000_0000;
    value_pool[3] = 32'sh7FFF_FFFF;
  endtask

  function automatic value_t pick_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return value_t'($urandom);
  endfunction

  function automatic op_t pick_op(int insert_pct, int remove_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) return OP_INSERT;
    if (r < insert_pct + remove_pct) return OP_REMOVE;
    if (r < 97) return OP_TEST;
    return OP_UNUSED;
  endfunction

  // receiver: own stall pattern, plus a long hold-off on demand
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    mode      = RX_FLOW;
    mode_left = 0;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        hold_left      = LONG_STALL;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          RX_FLOW:   rsp.ready <= 1'b1;
          RX_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
          default:   rsp.ready <= (cycle_count % 5 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    set_result_t head;
    if (!rst && rsp.valid && rsp.ready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending: ok=%0b count=%0d",
                 $time, rsp.ok, rsp.element_count);
        error_count++;
      end else begin
        head = expected_results.pop_front();
        if (rsp.ok !== head.ok) begin
          $display("%0t: ok mismatch: expected %0b, actual %0b", $time, head.ok, rsp.ok);
          error_count++;
        end
        if (rsp.element_count !== head.element_count) begin
          $display("%0t: element_count mismatch: expected %0d, actual %0d",
                   $time, head.element_count, rsp.element_count);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_set();
    send_request(OP_TEST,   32'sh0000_0000);
    send_request(OP_REMOVE, 32'sh8000_0000);
    send_request(OP_TEST,   32'sh7FFF_FFFF);
    send_request(OP_UNUSED, 32'shFFFF_FFFF);
  endtask

  task automatic test_directed_ops();
    send_request(OP_INSERT, 32'sh7FFF_FFFF);
    send_request(OP_INSERT, 32'sh8000_0000);
    send_request(OP_INSERT, 32'sh0000_0000);
    send_request(OP_INSERT, 32'shFFFF_FFFF);
    send_request(OP_INSERT, 32'sh5555_5555);
    send_request(OP_INSERT, 32'shAAAA_AAAA);
    // duplicate insert
    send_request(OP_INSERT, 32'sh0000_0000);
    send_request(OP_TEST,   32'sh8000_0000);
    send_request(OP_TEST,   32'sh0000_0001);
    // middle remove, then presence of the removed value and of the entry after it
    send_request(OP_REMOVE, 32'sh0000_0000);
    send_request(OP_TEST,   32'sh0000_0000);
    send_request(OP_TEST,   32'shFFFF_FFFF);
    send_request(OP_REMOVE, 32'sh0000_0000);
    send_request(OP_UNUSED, 32'sh5555_5555);
    send_request(OP_REMOVE, 32'sh7FFF_FFFF);
    send_request(OP_REMOVE, 32'shAAAA_AAAA);
    send_request(OP_TEST,   32'sh5555_5555);
    idle_cycles(3);
  endtask

  task automatic test_fill_to_capacity();
    refresh_pool();
    while (held_count < CAPACITY) begin
      send_request(OP_INSERT, pick_value());
      if ($urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 4));
    end
    repeat (6) send_request(OP_INSERT, value_t'($urandom));
    send_request(OP_INSERT, value_t'(held_values[CAPACITY / 2]));
    send_request(OP_TEST,   value_t'(held_values[CAPACITY - 1]));
    send_request(OP_REMOVE, value_t'(held_values[0]));
    send_request(OP_INSERT, value_t'($urandom));
    send_request(OP_TEST,   value_t'(held_values[0]));
  endtask

  task automatic test_backpressure();
    req.valid <= 1'b0;
    @(negedge clk);
    long_stall_req = 1'b1;
    @(posedge clk);
    repeat (24) send_request(pick_op(35, 35), pick_value());
  endtask

  task automatic test_quiet_pause();
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(int items, int insert_pct, int remove_pct);
    int sent;
    int burst;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < items; k++) begin
        send_request(pick_op(insert_pct, remove_pct), pick_value());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end
  endtask

  task automatic test_random_traffic();
    refresh_pool();
    run_random_phase(PHASE_ITEMS, 55, 15);
    refresh_pool();
    run_random_phase(PHASE_ITEMS, 20, 50);
    run_random_phase(PHASE_ITEMS, 35, 35);
  endtask

  initial begin
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.operation <= OP_INSERT;
    req.value     <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_set();
    test_directed_ops();
    test_fill_to_capacity();
    test_backpressure();
    test_quiet_pause();
    test_random_traffic();
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests and %0d results over %0d cycles", request_count,
             result_count, cycle_count);
    $display("%0d inserts and %0d removes took effect, %0d inserts refused on a full table",
             accepted_inserts, accepted_removes, full_refusals);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
